@@ rtl/gram_variance_iterative_sqrt_macros.svh @@
// Assertion macros used by the checker file of the variance block.
`ifndef GRAM_VARIANCE_ITERATIVE_SQRT_MACROS_SVH
`define GRAM_VARIANCE_ITERATIVE_SQRT_MACROS_SVH

// Check cons in the same cycle whenever ante holds; expects clk and rst_n in scope.
`define GVIS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds; expects clk and rst_n in scope.
`define GVIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gvis_pkg.sv @@
// Types, constants and fixed-point helpers of the variance and square root block.
package gvis_pkg;

    localparam int ITER_W  = 4;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int NUM_W   = 68;
    localparam int DIVD_W  = 64;
    localparam int DIVS_W  = 33;
    localparam int Q_W     = 32;

    localparam logic [ITER_W-1:0] ITER_RESET = 4'd6;

    localparam logic signed [NUM_W-1:0] ONE_Q   = 68'sd65536;
    localparam logic signed [NUM_W-1:0] TWO_Q   = 68'sd131072;
    localparam logic signed [NUM_W-1:0] THREE_Q = 68'sd196608;
    localparam logic signed [NUM_W-1:0] S32_MAX = 68'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [NUM_W-1:0] S32_MIN = -68'sh0_0000_0000_8000_0000;
    localparam logic signed [NUM_W-1:0] UNIT    = 68'sd1;

    localparam logic [Q_W-1:0] VAR_SAT       = 32'hFFFF_FFFF;
    localparam logic [Q_W-1:0] VAR_DOMAIN_HI = 32'h0003_0000;

    typedef struct packed {
        logic push;
        logic last;
        logic clear;
        logic rd_sel;
    } acc_ctrl_t;

    function automatic logic signed [31:0] sat32(input logic signed [NUM_W-1:0] x);
        if (x > S32_MAX) begin
            return 32'sh7FFF_FFFF;
        end
        else if (x < S32_MIN) begin
            return 32'sh8000_0000;
        end
        return $signed(x[31:0]);
    endfunction

    // Round half up at bit s, then clamp to the signed 32-bit range.
    function automatic logic signed [31:0] round_sat(input logic signed [PROD_W-1:0] p,
                                                     input int unsigned s);
        logic signed [NUM_W-1:0] q;
        q = NUM_W'(p) + (UNIT <<< (s - 1));
        q = q >>> s;
        return sat32(q);
    endfunction

endpackage

@@ rtl/gvis_accum.sv @@
// Per-component sums, sum of squares and vector count of the current set.
module gvis_accum
    import gvis_pkg::*;
#(
    parameter int MAX_VECTORS = 256,
    parameter int DIMENSION   = 1
)
(
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  acc_ctrl_t                                              ctrl,
    input  logic signed [15:0]                                     sample,
    input  logic [((DIMENSION > 1) ? $clog2(DIMENSION) : 1)-1:0]   rd_idx,
    output logic signed [17+$clog2(MAX_VECTORS)-1:0]               rd_sum,
    output logic [31+$clog2(MAX_VECTORS)+$clog2(DIMENSION)-1:0]    sum_sq,
    output logic [$clog2(MAX_VECTORS+1)-1:0]                       vec_count,
    output logic                                                   overflow
);

    localparam int IDX_W = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;
    localparam int SUM_W = 17 + $clog2(MAX_VECTORS);
    localparam int SQ_W  = 31 + $clog2(MAX_VECTORS) + $clog2(DIMENSION);
    localparam int CNT_W = $clog2(MAX_VECTORS + 1);

    logic signed [SUM_W-1:0] sums_reg [DIMENSION];
    logic [SQ_W-1:0]         sq_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    ovf_reg;

    logic [IDX_W-1:0]        rd_addr;
    logic signed [SUM_W-1:0] cur_sum;
    logic signed [31:0]      sq_prod;
    logic                    accept;
    logic                    end_vec;

    assign rd_addr = ctrl.rd_sel ? rd_idx : idx_reg;
    assign cur_sum = sums_reg[rd_addr];
    assign sq_prod = sample * sample;
    assign accept  = count_reg < CNT_W'(MAX_VECTORS);
    assign end_vec = ctrl.last || (idx_reg == IDX_W'(DIMENSION - 1));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int d = 0; d < DIMENSION; d++) begin
                sums_reg[d] <= '0;
            end
            sq_reg    <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (ctrl.clear) begin
            for (int d = 0; d < DIMENSION; d++) begin
                sums_reg[d] <= '0;
            end
            sq_reg    <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (ctrl.push) begin
            if (accept) begin
                sums_reg[idx_reg] <= cur_sum + SUM_W'(sample);
                sq_reg            <= sq_reg + SQ_W'(sq_prod[30:0]);
            end
            if (end_vec) begin
                idx_reg <= '0;
                if (accept) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else begin
                    ovf_reg <= 1'b1;
                end
            end
            else begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    assign rd_sum    = cur_sum;
    assign sum_sq    = sq_reg;
    assign vec_count = count_reg;
    assign overflow  = ovf_reg;

endmodule

@@ rtl/gvis_mul.sv @@
// Shared signed multiplier with a registered product.
module gvis_mul
    import gvis_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/gvis_div.sv @@
// Restoring divider, one quotient bit per cycle; dividend high half must be below divisor.
module gvis_div
    import gvis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [Q_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [Q_W-1:0]    shf_reg;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W+1:0] diff;
    logic              qbit;
    logic [DIVS_W-1:0] rem_next;

    assign trial    = {rem_reg, shf_reg[Q_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, divisor};
    assign qbit     = ~diff[DIVS_W+1];
    assign rem_next = qbit ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start) begin
                cnt_reg <= CNT_W'(Q_W);
            end
            else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= DIVS_W'(dividend[DIVD_W-1:Q_W]);
            shf_reg <= dividend[Q_W-1:0];
        end
        else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            shf_reg <= {shf_reg[Q_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = shf_reg;

endmodule

@@ rtl/gram_variance_iterative_sqrt.sv @@
// Top level: set accumulation, exact variance and multiplicative square root.
// Throughput: one sample transfer per cycle while a set is collected.
// The time from the last transfer of a set to the result grows with DIMENSION and
//   with sqrt_iterations; the 32-step divider and the shared multiplier set it.
// Saturated variance, or a negative difference set to zero, skips the divider.
// Reset (rst_n low, asynchronous): empty set, no result pending, sqrt_iterations = 6.
module gram_variance_iterative_sqrt
    import gvis_pkg::*;
#(
    parameter int MAX_VECTORS = 256,
    parameter int DIMENSION   = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Input stream: tdata = sample_value[15:0]; tlast = last_sample
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,
    input  logic              s_tlast,
    // Output stream: tdata = variance[31:0], std_dev[63:32], vector_total[72:64], zero pad
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [79:0]       m_tdata,
    // tuser = out_of_domain[0], set_overflow[1]
    output logic [1:0]        m_tuser,
    // Configuration: sqrt_iterations
    input  logic              cfg_wr_en,
    input  logic [ITER_W-1:0] cfg_wr_data
);

    localparam int IDX_W = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;
    localparam int SUM_W = 17 + $clog2(MAX_VECTORS);
    localparam int SQ_W  = 31 + $clog2(MAX_VECTORS) + $clog2(DIMENSION);
    localparam int CNT_W = $clog2(MAX_VECTORS + 1);

    typedef enum logic [4:0] {
        S_IDLE,   // collect samples
        S_GMUL,   // issue |sum[d]|^2
        S_GACC,   // add it to the Gram sum
        S_NLO,    // issue n * low word of the sum of squares
        S_NHI,    // take it, issue n * high word
        S_DEN,    // add high part, issue n * n
        S_DIFF,   // numerator minus Gram sum, latch n^2
        S_CHK,    // zero, saturate or start the divider
        S_DIV,    // wait for the quotient
        S_RINIT,  // seed a and b of the root
        S_LA,     // issue a * (2 - b)
        S_LB,     // new a, issue b * b
        S_LC,     // round b * b
        S_LD,     // issue bb * (b - 3)
        S_LE,     // new b, count the pass
        S_FA,     // final a step
        S_FB,     // clip the root
        S_DONE    // hand the result to the output register
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  d_reg;
    logic [ITER_W-1:0] it_reg;
    logic [ITER_W-1:0] iters_reg;

    logic              m_valid_reg;
    logic [79:0]       m_data_reg;
    logic [1:0]        m_user_reg;

    // Datapath registers of the final computation
    logic [NUM_W-1:0]   gram_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [NUM_W-1:0]   diff_reg;
    logic               borrow_reg;
    logic [DIVS_W-1:0]  den_reg;
    logic [Q_W-1:0]     var_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [31:0] bb_reg;
    logic [Q_W-1:0]     std_reg;

    acc_ctrl_t               acc_ctrl;
    logic signed [SUM_W-1:0] rd_sum;
    logic [SQ_W-1:0]         sum_sq;
    logic [CNT_W-1:0]        vec_count;
    logic                    overflow;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;

    logic                 div_start;
    logic                 div_done;
    logic [Q_W-1:0]       div_q;

    logic [SUM_W-1:0]     sum_mag;
    logic signed [MUL_W-1:0] mag_op;
    logic signed [MUL_W-1:0] n_op;
    logic [63:0]          sq_ext;
    logic signed [31:0]   t_sat;
    logic signed [31:0]   c_sat;
    logic signed [31:0]   a_init;
    logic signed [31:0]   root_fb;
    logic                 chk_sat;
    logic                 out_ready;
    logic                 in_xfer;
    logic [CNT_W+8:0]     cnt_ext;
    logic                 ood;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_ready = !m_valid_reg || m_tready;

    always_comb begin
        acc_ctrl.push   = in_xfer;
        acc_ctrl.last   = s_tlast;
        acc_ctrl.clear  = (state_reg == S_DONE) && out_ready;
        acc_ctrl.rd_sel = (state_reg != S_IDLE);
    end

    gvis_accum #(
        .MAX_VECTORS (MAX_VECTORS),
        .DIMENSION   (DIMENSION)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (acc_ctrl),
        .sample    ($signed(s_tdata)),
        .rd_idx    (d_reg),
        .rd_sum    (rd_sum),
        .sum_sq    (sum_sq),
        .vec_count (vec_count),
        .overflow  (overflow)
    );

    // Operand forms for the shared multiplier
    assign sum_mag = rd_sum[SUM_W-1] ? $unsigned(-rd_sum) : $unsigned(rd_sum);
    assign mag_op  = $signed(MUL_W'(sum_mag));
    assign n_op    = $signed(MUL_W'(vec_count));
    assign sq_ext  = 64'(sum_sq);
    assign t_sat   = sat32(TWO_Q - NUM_W'(b_reg));
    assign c_sat   = sat32(NUM_W'(b_reg) - THREE_Q);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_GMUL:
            begin
                mul_a = mag_op;
                mul_b = mag_op;
            end
            S_NLO:
            begin
                mul_a = n_op;
                mul_b = $signed(MUL_W'(sq_ext[31:0]));
            end
            S_NHI:
            begin
                mul_a = n_op;
                mul_b = $signed(MUL_W'(sq_ext[63:32]));
            end
            S_DEN:
            begin
                mul_a = n_op;
                mul_b = n_op;
            end
            S_LA, S_FA:
            begin
                mul_a = MUL_W'(a_reg);
                mul_b = MUL_W'(t_sat);
            end
            S_LB:
            begin
                mul_a = MUL_W'(b_reg);
                mul_b = MUL_W'(b_reg);
            end
            S_LD:
            begin
                mul_a = MUL_W'(bb_reg);
                mul_b = MUL_W'(c_sat);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    gvis_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Quotient above 32 bits saturates; otherwise the divider needs high half below n^2
    assign chk_sat   = (diff_reg[NUM_W-1:DIVD_W] != '0) ||
                       ({1'b0, diff_reg[DIVD_W-1:Q_W]} >= den_reg);
    assign div_start = (state_reg == S_CHK) && !borrow_reg && !chk_sat;

    gvis_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_reg[DIVD_W-1:0]),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign a_init  = var_reg[Q_W-1] ? 32'sh7FFF_FFFF : $signed(var_reg);
    assign root_fb = round_sat(prod, 17);
    assign cnt_ext = (CNT_W + 9)'(vec_count);
    assign ood     = (var_reg == '0) || (var_reg >= VAR_DOMAIN_HI);

    // Sequencer, configuration register and output register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            d_reg       <= '0;
            it_reg      <= '0;
            iters_reg   <= ITER_RESET;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_user_reg  <= '0;
        end
        else begin
            if (cfg_wr_en) begin
                iters_reg <= cfg_wr_data;
            end
            // Raise the result when the sequencer hands it over;
            // drop it once the downstream side takes it
            if ((state_reg == S_DONE) && out_ready) begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    d_reg <= '0;
                    if (in_xfer && s_tlast) begin
                        state_reg <= S_GMUL;
                    end
                end
                S_GMUL:
                begin
                    state_reg <= S_GACC;
                end
                S_GACC:
                begin
                    if (d_reg == IDX_W'(DIMENSION - 1)) begin
                        state_reg <= S_NLO;
                    end
                    else begin
                        d_reg     <= d_reg + IDX_W'(1);
                        state_reg <= S_GMUL;
                    end
                end
                S_NLO:  state_reg <= S_NHI;
                S_NHI:  state_reg <= S_DEN;
                S_DEN:  state_reg <= S_DIFF;
                S_DIFF: state_reg <= S_CHK;
                S_CHK:
                begin
                    if (borrow_reg || chk_sat) begin
                        state_reg <= S_RINIT;
                    end
                    else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done) begin
                        state_reg <= S_RINIT;
                    end
                end
                S_RINIT:
                begin
                    it_reg <= '0;
                    if (iters_reg == '0) begin
                        state_reg <= S_FA;
                    end
                    else begin
                        state_reg <= S_LA;
                    end
                end
                S_LA: state_reg <= S_LB;
                S_LB: state_reg <= S_LC;
                S_LC: state_reg <= S_LD;
                S_LD: state_reg <= S_LE;
                S_LE:
                begin
                    if (it_reg + ITER_W'(1) == iters_reg) begin
                        state_reg <= S_FA;
                    end
                    else begin
                        it_reg    <= it_reg + ITER_W'(1);
                        state_reg <= S_LA;
                    end
                end
                S_FA: state_reg <= S_FB;
                S_FB: state_reg <= S_DONE;
                S_DONE:
                begin
                    // Hold here until the output register is free
                    if (out_ready) begin
                        m_data_reg  <= {7'd0, cnt_ext[8:0], std_reg, var_reg};
                        m_user_reg  <= {overflow, ood};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Wide datapath registers; each state that takes a product consumes the one issued by the state before
    always_ff @(posedge clk) begin
        case (state_reg)
            S_IDLE:
            begin
                gram_reg <= '0;
            end
            S_GACC:
            begin
                gram_reg <= gram_reg + NUM_W'(prod[63:0]);
            end
            S_NHI:
            begin
                num_reg <= NUM_W'(prod[63:0]);
            end
            S_DEN:
            begin
                num_reg <= num_reg + NUM_W'({prod[35:0], 32'd0});
            end
            S_DIFF:
            begin
                {borrow_reg, diff_reg} <= {1'b0, num_reg} - {1'b0, gram_reg};
                den_reg <= prod[DIVS_W-1:0];
            end
            S_CHK:
            begin
                if (borrow_reg) begin
                    var_reg <= '0;
                end
                else if (chk_sat) begin
                    var_reg <= VAR_SAT;
                end
            end
            S_DIV:
            begin
                if (div_done) begin
                    var_reg <= div_q;
                end
            end
            S_RINIT:
            begin
                a_reg <= a_init;
                b_reg <= a_init - 32'sd65536;
            end
            S_LB:
            begin
                a_reg <= round_sat(prod, 17);
            end
            S_LC:
            begin
                bb_reg <= round_sat(prod, 16);
            end
            S_LE:
            begin
                b_reg <= round_sat(prod, 18);
            end
            S_FB:
            begin
                std_reg <= root_fb[31] ? '0 : $unsigned(root_fb);
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

@@ rtl/gvis_checker.sv @@
// Port-level checks of the variance block and their binding to the top level.
`include "gram_variance_iterative_sqrt_macros.svh"

module gvis_checker
    import gvis_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [79:0]       m_tdata,
    input logic [1:0]        m_tuser
);

    // A stalled result holds its payload
    `GVIS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Closing a set stops the input side while the result is worked out
    `GVIS_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "input ready after last transfer")

    // The domain flag agrees with the variance it travels with
    `GVIS_ASSERT_SAME(a_domain_flag, m_tvalid, m_tuser[0] == ((m_tdata[31:0] == 32'd0) || (m_tdata[31:0] >= VAR_DOMAIN_HI)), "domain flag disagrees with variance")

    // A new result only appears out of the busy phase
    `GVIS_ASSERT_SAME(a_result_from_busy, $rose(m_tvalid), !$past(s_tready), "result appeared while collecting")

endmodule

bind gram_variance_iterative_sqrt gvis_checker u_gvis_checker (.*);
